[rtl/tcs_pkg.sv]
package tcs_pkg;

  localparam int unsigned MaxChannels = 64;
  localparam int unsigned MaxTaps     = 16;
  localparam int unsigned MaxOutLen   = 256;

  localparam int unsigned ChW   = $clog2(MaxChannels);
  localparam int unsigned TapW  = $clog2(MaxTaps);
  localparam int unsigned PosW  = $clog2(MaxOutLen);
  localparam int unsigned WgtAw = 2 * ChW + TapW;
  localparam int unsigned AccAw = ChW + PosW;
  localparam int unsigned AccDepth = 1 << AccAw;
  localparam int unsigned WgtDepth = 1 << WgtAw;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_SEED   = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_IN_PER_GROUP  = 3'd0,
    REG_OUT_PER_GROUP = 3'd1,
    REG_OUT_LENGTH    = 3'd2,
    REG_TAP_COUNT     = 3'd3,
    REG_STRIDE        = 3'd4,
    REG_DILATION      = 3'd5,
    REG_LEFT_PAD      = 3'd6
  } reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_SETUP,
    ST_FETCH,
    ST_MUL,
    ST_WB,
    ST_READ
  } state_e;

  typedef struct packed {
    logic          start;
    logic [ChW-1:0] dividend;
    logic [ChW:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [ChW-1:0] quotient;
  } div_rsp_t;

endpackage

[rtl/tcs_ram.sv]
module tcs_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tcs_div.sv]
module tcs_div
  import tcs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [ChW-1:0]         rem_q, rem_d;
  logic [ChW-1:0]         quo_q, quo_d;
  logic [ChW-1:0]         num_q, num_d;
  logic [ChW:0]           den_q, den_d;
  logic [$clog2(ChW):0]   cnt_q, cnt_d;
  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [ChW:0]           trial;

  // one quotient bit per cycle, most significant first
  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    num_d  = num_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, num_q[ChW-1]};
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = '0;
      num_d  = req_i.dividend;
      den_d  = req_i.divisor;
      cnt_d  = ($clog2(ChW)+1)'(ChW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      num_d = {num_q[ChW-2:0], 1'b0};
      if (trial >= den_q) begin
        rem_d = ChW'(trial - den_q);
        quo_d = {quo_q[ChW-2:0], 1'b1};
      end else begin
        rem_d = trial[ChW-1:0];
        quo_d = {quo_q[ChW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == ($clog2(ChW)+1)'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    num_q <= num_d;
    den_q <= den_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

[rtl/transposed_conv1d_int32_scatter.sv]
// Grouped, strided, dilated 1-D transposed convolution on int32 data in scatter
// form. Weights (64x64x16), bias seeds (64) and accumulators (64 channels x 256
// positions) sit in single-write, single-read synchronous RAMs. After reset the
// block sweeps the accumulator RAM to zero, one entry a cycle, and takes no
// request meanwhile (configuration writes still land). A read passes through
// ST_READ, which waits for room on the output side. A sample runs the
// channel-group divide and setup, then per (output channel, tap) pair an
// accumulator read, multiply and write-back, skipping pairs whose position falls
// outside the output and rows whose channel is out of range; the pairs go one at
// a time through the accumulator RAM's single read-modify-write loop. Registers
// live at byte address 4*i.
module transposed_conv1d_int32_scatter
  import tcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: in_chan[5:0], out_chan[11:6], pos[19:12], tap_index[23:20],
  // data_word[55:24]
  input  logic [55:0] s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_value[31:0]
  output logic [31:0] m_axis_tdata,
  // tuser: bad_index[0]
  output logic        m_axis_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration
  logic [6:0] ipg_q, opg_q;
  logic [8:0] olen_q;
  logic [4:0] taps_q, stride_q, dil_q;
  logic [7:0] pad_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipg_q    <= 7'd1;
      opg_q    <= 7'd1;
      olen_q   <= 9'd256;
      taps_q   <= 5'd1;
      stride_q <= 5'd1;
      dil_q    <= 5'd1;
      pad_q    <= 8'd0;
    end else if (cfg_we && paddr[1:0] == 2'b00) begin
      unique case (paddr[4:2])
        REG_IN_PER_GROUP:  ipg_q    <= pwdata[6:0];
        REG_OUT_PER_GROUP: opg_q    <= pwdata[6:0];
        REG_OUT_LENGTH:    olen_q   <= pwdata[8:0];
        REG_TAP_COUNT:     taps_q   <= pwdata[4:0];
        REG_STRIDE:        stride_q <= pwdata[4:0];
        REG_DILATION:      dil_q    <= pwdata[4:0];
        REG_LEFT_PAD:      pad_q    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[4:2])
        REG_IN_PER_GROUP:  prdata = {25'd0, ipg_q};
        REG_OUT_PER_GROUP: prdata = {25'd0, opg_q};
        REG_OUT_LENGTH:    prdata = {23'd0, olen_q};
        REG_TAP_COUNT:     prdata = {27'd0, taps_q};
        REG_STRIDE:        prdata = {27'd0, stride_q};
        REG_DILATION:      prdata = {27'd0, dil_q};
        REG_LEFT_PAD:      prdata = {24'd0, pad_q};
        default:           prdata = '0;
      endcase
    end
  end

  // effective sizes
  logic [6:0] ipg_eff, opg_eff;
  logic [4:0] taps_eff;
  logic [8:0] olen_eff;

  assign ipg_eff  = (ipg_q == 7'd0) ? 7'd1 :
                    (ipg_q > 7'(MaxChannels)) ? 7'(MaxChannels) : ipg_q;
  assign opg_eff  = (opg_q > 7'(MaxChannels)) ? 7'(MaxChannels) : opg_q;
  assign taps_eff = (taps_q > 5'(MaxTaps)) ? 5'(MaxTaps) : taps_q;
  assign olen_eff = (olen_q > 9'(MaxOutLen)) ? 9'(MaxOutLen) : olen_q;

  // request fields
  logic [ChW-1:0]  f_ic, f_oc;
  logic [PosW-1:0] f_pos;
  logic [TapW-1:0] f_tap;
  logic [31:0]     f_data;
  cmd_e            f_cmd;
  logic            in_acc;

  assign f_ic   = s_axis_tdata[5:0];
  assign f_oc   = s_axis_tdata[11:6];
  assign f_pos  = s_axis_tdata[19:12];
  assign f_tap  = s_axis_tdata[23:20];
  assign f_data = s_axis_tdata[55:24];
  assign f_cmd  = cmd_e'(s_axis_tuser);
  assign in_acc = s_axis_tvalid && s_axis_tready;

  state_e state_q, state_d;
  logic [ChW-1:0]  ic_q;
  logic [PosW-1:0] pos_q;
  logic [31:0]     data_q;
  logic            bad_q;
  logic [AccAw:0]  clr_q, clr_d;
  logic [6:0]      j_q, j_d;
  logic [4:0]      k_q, k_d;
  logic [11:0]     tbase_q;
  logic signed [14:0] base_q;
  logic [31:0]     prod_q;
  logic            out_valid_q, out_valid_d;
  logic [31:0]     out_value_q;
  logic            out_bad_q;

  div_req_t div_req;
  div_rsp_t div_rsp;

  tcs_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // scatter target of the current (channel, tap) pair
  logic [12:0]        target;
  logic               target_ok;
  logic signed [14:0] idx;
  logic               idx_ok;
  logic               last_k, last_j;

  assign target    = 13'(tbase_q) + 13'(j_q);
  assign target_ok = target < 13'(MaxChannels);
  assign idx       = base_q + $signed({5'd0, 10'(k_q * dil_q)});
  assign idx_ok    = !idx[14] && (idx[13:0] < 14'(olen_eff));
  assign last_k    = (k_q + 5'd1) >= taps_eff;
  assign last_j    = (j_q + 7'd1) >= opg_eff;

  // memories
  logic             w_we, w_re;
  logic [WgtAw-1:0] w_waddr, w_raddr;
  logic [31:0]      w_rdata;
  logic             s_we, s_re;
  logic [31:0]      s_rdata;
  logic             a_we, a_re;
  logic [AccAw-1:0] a_waddr, a_raddr;
  logic [31:0]      a_wdata, a_rdata;
  logic [AccAw-1:0] a_addr_q;

  tcs_ram #(.Width(32), .Depth(WgtDepth)) u_wgt_ram (
    .clk_i (clk_i), .we_i (w_we), .waddr_i (w_waddr), .wdata_i (f_data),
    .re_i (w_re), .raddr_i (w_raddr), .rdata_o (w_rdata)
  );

  tcs_ram #(.Width(32), .Depth(MaxChannels)) u_seed_ram (
    .clk_i (clk_i), .we_i (s_we), .waddr_i (f_oc), .wdata_i (f_data),
    .re_i (s_re), .raddr_i (f_oc), .rdata_o (s_rdata)
  );

  tcs_ram #(.Width(32), .Depth(AccDepth)) u_acc_ram (
    .clk_i (clk_i), .we_i (a_we), .waddr_i (a_waddr), .wdata_i (a_wdata),
    .re_i (a_re), .raddr_i (a_raddr), .rdata_o (a_rdata)
  );

  assign w_waddr = {f_ic, f_oc, f_tap};
  assign w_raddr = {ic_q, j_q[ChW-1:0], k_q[TapW-1:0]};

  // saturating product
  logic signed [63:0] full_prod;
  logic [31:0]        sat_prod;

  assign full_prod = $signed(data_q) * $signed(w_rdata);
  always_comb begin
    if (full_prod[63:31] == '0 || full_prod[63:31] == '1) begin
      sat_prod = full_prod[31:0];
    end else if (full_prod[63]) begin
      sat_prod = 32'h8000_0000;
    end else begin
      sat_prod = 32'h7fff_ffff;
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    state_d       = state_q;
    clr_d         = clr_q;
    j_d           = j_q;
    k_d           = k_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    s_axis_tready = (state_q == ST_IDLE);
    div_req       = '0;
    w_we          = 1'b0;
    w_re          = 1'b0;
    s_we          = 1'b0;
    s_re          = 1'b0;
    a_we          = 1'b0;
    a_re          = 1'b0;
    a_waddr       = a_addr_q;
    a_wdata       = a_rdata + prod_q;
    a_raddr       = {f_oc, f_pos};
    unique case (state_q)
      ST_CLEAR: begin
        a_we    = 1'b1;
        a_waddr = clr_q[AccAw-1:0];
        a_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == (AccAw+1)'(AccDepth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (f_cmd)
            CMD_WEIGHT: w_we = 1'b1;
            CMD_SEED:   s_we = 1'b1;
            CMD_SAMPLE: begin
              div_req.start    = 1'b1;
              div_req.dividend = f_ic;
              div_req.divisor  = ipg_eff;
              state_d          = ST_DIV;
            end
            CMD_READ: begin
              a_re    = 1'b1;
              s_re    = 1'b1;
              state_d = ST_READ;
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        j_d = '0;
        k_d = '0;
        state_d = (opg_eff == 7'd0 || taps_eff == 5'd0) ? ST_IDLE : ST_FETCH;
      end
      ST_FETCH: begin
        a_raddr = {target[ChW-1:0], idx[PosW-1:0]};
        if (target_ok && idx_ok) begin
          a_re    = 1'b1;
          w_re    = 1'b1;
          state_d = ST_MUL;
        end else begin
          // skip this pair, or the whole row when the channel is out of range
          if (!target_ok || last_k) begin
            k_d = '0;
            j_d = j_q + 7'd1;
            if (last_j) begin
              state_d = ST_IDLE;
            end
          end else begin
            k_d = k_q + 5'd1;
          end
        end
      end
      ST_MUL: begin
        state_d = ST_WB;
      end
      ST_WB: begin
        a_we = 1'b1;
        if (last_k) begin
          k_d = '0;
          j_d = j_q + 7'd1;
          state_d = last_j ? ST_IDLE : ST_FETCH;
        end else begin
          k_d = k_q + 5'd1;
          state_d = ST_FETCH;
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          if (!bad_q) begin
            a_we    = 1'b1;
            a_wdata = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      j_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      j_q         <= j_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ic_q   <= f_ic;
      pos_q  <= f_pos;
      data_q <= f_data;
      bad_q  <= {1'b0, f_pos} >= olen_eff;
      a_addr_q <= {f_oc, f_pos};
    end
    if (state_q == ST_DIV && div_rsp.done) begin
      tbase_q <= 12'(div_rsp.quotient * opg_eff);
      base_q  <= $signed({2'd0, 13'(pos_q * stride_q)}) - $signed({7'd0, pad_q});
    end
    if (state_q == ST_FETCH) begin
      a_addr_q <= {target[ChW-1:0], idx[PosW-1:0]};
    end
    if (state_q == ST_MUL) begin
      prod_q <= sat_prod;
    end
    if (state_q == ST_READ && out_free) begin
      out_bad_q   <= bad_q;
      out_value_q <= bad_q ? 32'd0 : a_rdata + s_rdata;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_bad_q;

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
  import tcs_pkg::*;

  localparam int unsigned DrainCycles = 3400;
  localparam int unsigned CycleLimit  = 4000000;

  typedef struct {
    cmd_e        cmd;
    logic [5:0]  ic;
    logic [5:0]  oc;
    logic [7:0]  pos;
    logic [3:0]  tap;
    logic [31:0] data;
  } req_t;

  typedef struct {
    logic [31:0] value;
    logic        bad;
  } out_t;

  typedef struct {
    cmd_e        cmd;
    logic [5:0]  ic;
    logic [5:0]  oc;
    logic [7:0]  pos;
    logic [3:0]  tap;
    logic [31:0] data;
    bit          known;
    logic [31:0] value;
    logic        bad;
  } row_t;

  typedef struct {
    int j;
    int target;
    int idx;
    int k;
  } hit_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  transposed_conv1d_int32_scatter dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // shadow state of the convolution
  logic [31:0] weight_mem [WgtDepth];
  bit          weight_set [WgtDepth];
  logic [31:0] seed_mem [MaxChannels];
  bit          seed_set [MaxChannels];
  logic [31:0] acc_mem [AccDepth];
  logic [31:0] cfg_val [7];
  logic [31:0] cfg_mask [7] = '{32'h7f, 32'h7f, 32'h1ff, 32'h1f, 32'h1f, 32'h1f, 32'hff};

  out_t pending_q [$];
  int   mismatches = 0;
  int   idle_mode = 0;   // 0 none, 1 sender, 2 receiver, 3 both
  int   cycles = 0;

  function automatic int unsigned clamp_to(int unsigned v, int unsigned hi);
    return v > hi ? hi : v;
  endfunction

  function automatic int unsigned eff_len();
    return clamp_to(cfg_val[REG_OUT_LENGTH], MaxOutLen);
  endfunction

  function automatic logic [31:0] sat_product(logic [31:0] a, logic [31:0] b);
    longint p;
    p = longint'($signed(a)) * longint'($signed(b));
    if (p > 64'sd2147483647) p = 64'sd2147483647;
    if (p < -64'sd2147483648) p = -64'sd2147483648;
    return p[31:0];
  endfunction

  function automatic int wgt_addr(int ic, int j, int k);
    return (ic * MaxChannels + j) * MaxTaps + k;
  endfunction

  // list every (offset, tap) pair a sample lands on inside the output
  function automatic void scatter_hits(input logic [5:0] ic, input logic [7:0] pos,
                                       ref hit_t hits[$]);
    int unsigned ipg, opg, taps, grp;
    int base, idx, target;
    hits.delete();
    ipg  = clamp_to(cfg_val[REG_IN_PER_GROUP] == 0 ? 1 : cfg_val[REG_IN_PER_GROUP],
                    MaxChannels);
    opg  = clamp_to(cfg_val[REG_OUT_PER_GROUP], MaxChannels);
    taps = clamp_to(cfg_val[REG_TAP_COUNT], MaxTaps);
    grp  = ic / ipg;
    base = int'(pos) * int'(cfg_val[REG_STRIDE]) - int'(cfg_val[REG_LEFT_PAD]);
    for (int j = 0; j < opg; j++) begin
      target = grp * opg + j;
      if (target >= MaxChannels) continue;
      for (int k = 0; k < taps; k++) begin
        idx = base + k * int'(cfg_val[REG_DILATION]);
        if (idx < 0 || idx >= int'(eff_len())) continue;
        hits.push_back('{j: j, target: target, idx: idx, k: k});
      end
    end
  endfunction

  function automatic bit conv_step(input req_t r, output out_t res);
    hit_t hits[$];
    int a;
    res = '{value: '0, bad: 1'b0};
    case (r.cmd)
      CMD_WEIGHT: begin
        weight_mem[wgt_addr(r.ic, r.oc, r.tap)] = r.data;
        weight_set[wgt_addr(r.ic, r.oc, r.tap)] = 1'b1;
        return 1'b0;
      end
      CMD_SEED: begin
        seed_mem[r.oc] = r.data;
        seed_set[r.oc] = 1'b1;
        return 1'b0;
      end
      CMD_SAMPLE: begin
        scatter_hits(r.ic, r.pos, hits);
        foreach (hits[h]) begin
          a = hits[h].target * MaxOutLen + hits[h].idx;
          acc_mem[a] = acc_mem[a] +
                       sat_product(r.data, weight_mem[wgt_addr(r.ic, hits[h].j, hits[h].k)]);
        end
        return 1'b0;
      end
      default: begin
        if (r.pos >= eff_len()) begin
          res.bad = 1'b1;
        end else begin
          a = r.oc * MaxOutLen + r.pos;
          res.value = acc_mem[a] + seed_mem[r.oc];
          acc_mem[a] = '0;
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic gap_sender();
    if (idle_mode == 1 || idle_mode == 3) begin
      while ($urandom_range(99) < (idle_mode == 1 ? 71 : 27)) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
    end
  endtask

  // entered at a falling edge, returns at a falling edge
  task automatic put_req(input req_t r, input bit known = 0,
                         input logic [31:0] kval = '0, input logic kbad = 1'b0);
    out_t res;
    gap_sender();
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {r.data, r.tap, r.pos, r.oc, r.ic};
    s_axis_tuser  = r.cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    if (conv_step(r, res)) begin
      if (known) pending_q.push_back('{value: kval, bad: kbad});
      else pending_q.push_back(res);
    end
    @(negedge clk_i);
  endtask

  // write any weight or seed a request would read before it goes out
  task automatic put_safe(input req_t r);
    hit_t hits[$];
    req_t w;
    if (r.cmd == CMD_SAMPLE) begin
      scatter_hits(r.ic, r.pos, hits);
      foreach (hits[h]) begin
        if (!weight_set[wgt_addr(r.ic, hits[h].j, hits[h].k)]) begin
          w = '{cmd: CMD_WEIGHT, ic: r.ic, oc: 6'(hits[h].j), pos: 8'($urandom),
                tap: 4'(hits[h].k), data: $urandom};
          put_req(w);
        end
      end
    end else if (r.cmd == CMD_READ && r.pos < eff_len() && !seed_set[r.oc]) begin
      w = '{cmd: CMD_SEED, ic: 6'($urandom), oc: r.oc, pos: 8'($urandom),
            tap: 4'($urandom), data: $urandom};
      put_req(w);
    end
    put_req(r);
  endtask

  task automatic apb_write(input reg_e idx, input logic [31:0] value);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00}; pwdata = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
    cfg_val[idx] = value & cfg_mask[idx];
    // read back
    @(negedge clk_i);
    psel = 1'b1; pwrite = 1'b0;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    if ((prdata & cfg_mask[idx]) !== cfg_val[idx]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %0d readback: expected %h, got %h", idx, cfg_val[idx], prdata);
    end
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0;
  endtask

  task automatic drain_wait();
    s_axis_tvalid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %h bad %b", m_axis_tdata, m_axis_tuser);
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tdata !== want.value || m_axis_tuser !== want.bad) begin
          mismatches++;
          if (mismatches <= 10)
            $display("read mismatch: expected value %h bad %b, got value %h bad %b",
                     want.value, want.bad, m_axis_tdata, m_axis_tuser);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    case (idle_mode)
      2: m_axis_tready <= $urandom_range(99) >= 71;
      3: m_axis_tready <= $urandom_range(99) >= 27;
      default: m_axis_tready <= 1'b1;
    endcase
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  row_t plan [] = '{
    '{CMD_SEED,   0, 0,  0,  0, 32'h7fffffff, 0, 0, 0},
    '{CMD_READ,   0, 0,  0,  0, 32'h0,        1, 32'h7fffffff, 0},
    '{CMD_SEED,   0, 63, 0,  0, 32'h80000000, 0, 0, 0},
    '{CMD_READ,   0, 63, 255, 0, 32'h0,       1, 32'h80000000, 0},
    '{CMD_WEIGHT, 0, 0,  0,  0, 32'h7fffffff, 0, 0, 0},
    '{CMD_SAMPLE, 0, 0,  0,  0, 32'h7fffffff, 0, 0, 0},
    '{CMD_READ,   0, 0,  0,  0, 32'h0,        1, 32'hfffffffe, 0},
    '{CMD_WEIGHT, 1, 0,  0,  0, 32'h80000000, 0, 0, 0},
    '{CMD_SEED,   0, 1,  0,  0, 32'h0,        0, 0, 0},
    '{CMD_SAMPLE, 1, 0,  5,  0, 32'h80000000, 0, 0, 0},
    '{CMD_READ,   0, 1,  5,  0, 32'h0,        1, 32'h7fffffff, 0},
    '{CMD_SAMPLE, 1, 0,  3,  0, 32'hffffffff, 0, 0, 0},
    '{CMD_READ,   0, 1,  3,  0, 32'h0,        1, 32'h7fffffff, 0},
    '{CMD_WEIGHT, 3, 0,  0, 15, 32'h12345678, 0, 0, 0},
    '{CMD_WEIGHT, 3, 0,  0,  0, 32'h7fffffff, 0, 0, 0},
    '{CMD_SEED,   0, 3,  0,  0, 32'h0,        0, 0, 0},
    '{CMD_SAMPLE, 3, 0,  9,  0, 32'h80000000, 0, 0, 0},
    '{CMD_READ,   0, 3,  9,  0, 32'h0,        1, 32'h80000000, 0},
    '{CMD_READ,   0, 3,  9,  0, 32'h0,        1, 32'h0, 0},
    '{CMD_SAMPLE, 63, 0, 255, 0, 32'h00000003, 0, 0, 0},
    '{CMD_READ,   63, 63, 255, 15, 32'hffffffff, 0, 0, 0}
  };

  initial begin
    req_t r;
    int   n_items, ic_hi, oc_hi, roll, olen;
    logic [31:0] pset [7];
    for (int i = 0; i < WgtDepth; i++) weight_set[i] = 1'b0;
    for (int i = 0; i < MaxChannels; i++) seed_set[i] = 1'b0;
    for (int i = 0; i < AccDepth; i++) acc_mem[i] = '0;
    cfg_val = '{32'd1, 32'd1, 32'd256, 32'd1, 32'd1, 32'd1, 32'd0};
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (plan[i]) begin
      r = '{cmd: plan[i].cmd, ic: plan[i].ic, oc: plan[i].oc, pos: plan[i].pos,
            tap: plan[i].tap, data: plan[i].data};
      put_safe(r);
      if (plan[i].known) begin
        // swap the predicted read for the typed value
        void'(pending_q.pop_back());
        pending_q.push_back('{value: plan[i].value, bad: plan[i].bad});
      end
    end

    for (int ph = 0; ph < 12; ph++) begin
      drain_wait();
      idle_mode = ph % 4;
      case (ph)
        1: pset = '{32'd64, 32'd64, 32'd256, 32'd16, 32'd16, 32'd16, 32'd255};
        4: pset = '{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
        7: pset = '{32'hffffffff, 32'hffffff7f, 32'hfffffdff, 32'hffffffff,
                    32'h1, 32'h1f, 32'h0};
        9: pset = '{32'd1, 32'd2, 32'd256, 32'd4, 32'd0, 32'd0, 32'd0};
        default: pset = '{$urandom_range(1, 8), $urandom_range(1, 4),
                          $urandom_range(8, 64), $urandom_range(1, 4),
                          $urandom_range(0, 4), $urandom_range(0, 3),
                          $urandom_range(0, 10)};
      endcase
      for (int i = 0; i < 7; i++) apb_write(reg_e'(i), pset[i]);
      n_items = (ph == 1 || ph == 7) ? 30 : (ph == 4 ? 60 : 120);
      ic_hi   = (ph == 1 || ph == 7) ? 1 : 15;
      olen    = eff_len();
      for (int n = 0; n < n_items; n++) begin
        roll = $urandom_range(99);
        r.ic  = 6'($urandom_range(0, ic_hi));
        r.tap = 4'($urandom);
        r.data = $urandom_range(1) ? $urandom : $urandom_range(0, 200) - 100;
        r.pos = 8'($urandom);
        oc_hi = $urandom_range(3) == 0 ? 63 : 15;
        r.oc  = 6'($urandom_range(0, oc_hi));
        if (roll < 40) begin
          r.cmd = CMD_SAMPLE;
          if ($urandom_range(3) != 0)
            r.pos = 8'($urandom_range(0, clamp_to(olen + 3, 255)));
        end else if (roll < 80) begin
          r.cmd = CMD_READ;
          if ($urandom_range(4) != 0)
            r.pos = 8'($urandom_range(0, clamp_to(olen + 3, 255)));
        end else if (roll < 90) begin
          r.cmd = CMD_WEIGHT;
          r.oc  = 6'($urandom_range(0, 7));
          if ($urandom_range(9) == 0) r.oc = 6'($urandom);
        end else begin
          r.cmd = CMD_SEED;
          r.oc  = 6'($urandom);
        end
        put_safe(r);
      end
    end

    s_axis_tvalid = 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tcs_pkg.sv
rtl/tcs_ram.sv
rtl/tcs_div.sv
rtl/transposed_conv1d_int32_scatter.sv
tb/tb.sv
